// File: hw/rtl/tbgd_pkg.sv
// ----------------------------------------------------------------------------
// tbgd_pkg
// Shared types and constants for the two-button gesture detector.
// ----------------------------------------------------------------------------
package tbgd_pkg;

   localparam int unsigned CountWidth = 10;
   localparam int unsigned EventWidth = 5;

   localparam logic [CountWidth-1:0] HOLD_RESET = 10'd500;

   localparam logic [1:0] BOTH_PRESSED = 2'b11;
   localparam logic [1:0] NONE_PRESSED = 2'b00;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_TAKE = 1'b1;

   localparam int unsigned EV_LEFT_TAP     = 0;
   localparam int unsigned EV_RIGHT_TAP    = 1;
   localparam int unsigned EV_BOTH_TAP     = 2;
   localparam int unsigned EV_BOTH_HOLD    = 3;
   localparam int unsigned EV_ALL_RELEASED = 4;

   // only all_released latched
   localparam logic [EventWidth-1:0] EVENTS_RESET = 5'b1_0000;

   typedef logic [CountWidth-1:0] count_type;

   typedef struct packed {
      logic left_tap;
      logic right_tap;
      logic both_tap;
      logic both_hold;
      logic all_released;
      logic left_held;
      logic right_held;
   } rsp_type;

endpackage

// File: hw/rtl/tbgd_core.sv
// ----------------------------------------------------------------------------
// tbgd_core
// Gesture state registers and their per-request update.
// ----------------------------------------------------------------------------
module tbgd_core
   import tbgd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_fire,
   input  logic      func,
   input  logic [1:0] pressed,
   input  count_type threshold,
   output rsp_type   snapshot
);

   count_type                 single_count_ff [2];
   count_type                 single_count_in [2];
   count_type                 both_count_ff;
   count_type                 both_count_in;
   logic [1:0]                release_pending_ff;
   logic [1:0]                release_pending_in;
   logic [EventWidth-1:0]     events_ff;
   logic [EventWidth-1:0]     events_in;
   logic [1:0]                held_ff;
   logic [1:0]                held_in;
   logic                      both_active_ff;
   logic                      both_active_in;
   logic                      blocked_ff;
   logic                      blocked_in;
   logic                      any_pressed_ff;
   logic                      any_pressed_in;

   always_comb begin
      single_count_in[0] = single_count_ff[0];
      single_count_in[1] = single_count_ff[1];
      both_count_in      = both_count_ff;
      release_pending_in = release_pending_ff;
      events_in          = events_ff;
      held_in            = held_ff;
      both_active_in     = both_active_ff;
      blocked_in         = blocked_ff;
      any_pressed_in     = any_pressed_ff;

      if (req_fire && func == FUNC_TAKE) begin
         events_in = '0;
      end else if (req_fire && func == FUNC_TICK) begin
         held_in = 2'b00;
         if (pressed == NONE_PRESSED) begin
            if (any_pressed_ff) begin
               events_in[EV_ALL_RELEASED] = 1'b1;
            end
            if (!blocked_ff) begin
               if (both_active_ff) begin
                  events_in[EV_BOTH_TAP] = 1'b1;
               end else begin
                  events_in[EV_RIGHT_TAP:EV_LEFT_TAP] =
                     events_in[EV_RIGHT_TAP:EV_LEFT_TAP] | release_pending_ff;
               end
            end
            single_count_in[0] = '0;
            single_count_in[1] = '0;
            both_count_in      = '0;
            release_pending_in = 2'b00;
            both_active_in     = 1'b0;
            blocked_in         = 1'b0;
            any_pressed_in     = 1'b0;
         end else begin
            any_pressed_in = 1'b1;
            events_in[EV_ALL_RELEASED] = 1'b0;
            if (!blocked_ff) begin
               if (pressed == BOTH_PRESSED && single_count_ff[0] < threshold &&
                   single_count_ff[1] < threshold) begin
                  both_active_in     = 1'b1;
                  release_pending_in = 2'b00;
                  single_count_in[0] = '0;
                  single_count_in[1] = '0;
                  if (both_count_ff < threshold) begin
                     both_count_in = both_count_ff + 1'b1;
                  end
                  if (both_count_in == threshold) begin
                     events_in[EV_BOTH_HOLD] = 1'b1;
                     blocked_in = 1'b1;
                  end
               end else if (!both_active_ff) begin
                  for (int n = 0; n < 2; n++) begin
                     if (pressed[n]) begin
                        release_pending_in[n] = 1'b1;
                        if (single_count_ff[n] < threshold) begin
                           single_count_in[n] = single_count_ff[n] + 1'b1;
                        end
                        if (single_count_in[n] == threshold) begin
                           held_in[n] = 1'b1;
                        end
                     end else if (release_pending_ff[n]) begin
                        events_in[n]          = 1'b1;
                        release_pending_in[n] = 1'b0;
                        single_count_in[n]    = '0;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_count_ff[0] <= '0;
         single_count_ff[1] <= '0;
         both_count_ff      <= '0;
         release_pending_ff <= 2'b00;
         events_ff          <= EVENTS_RESET;
         held_ff            <= 2'b00;
         both_active_ff     <= 1'b0;
         blocked_ff         <= 1'b1;
         any_pressed_ff     <= 1'b0;
      end else begin
         single_count_ff[0] <= single_count_in[0];
         single_count_ff[1] <= single_count_in[1];
         both_count_ff      <= both_count_in;
         release_pending_ff <= release_pending_in;
         events_ff          <= events_in;
         held_ff            <= held_in;
         both_active_ff     <= both_active_in;
         blocked_ff         <= blocked_in;
         any_pressed_ff     <= any_pressed_in;
      end
   end

   assign snapshot.left_tap     = events_ff[EV_LEFT_TAP];
   assign snapshot.right_tap    = events_ff[EV_RIGHT_TAP];
   assign snapshot.both_tap     = events_ff[EV_BOTH_TAP];
   assign snapshot.both_hold    = events_ff[EV_BOTH_HOLD];
   assign snapshot.all_released = events_ff[EV_ALL_RELEASED];
   assign snapshot.left_held    = held_ff[0];
   assign snapshot.right_held   = held_ff[1];

endmodule

// File: hw/rtl/tbgd_rsp_buf.sv
// ----------------------------------------------------------------------------
// tbgd_rsp_buf
// Two-entry output register with skid slot for the response channel.
// ----------------------------------------------------------------------------
module tbgd_rsp_buf
   import tbgd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    pop;

   assign pop = out_valid_ff && rsp_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space     = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: hw/rtl/two_button_gesture_detector.sv
// ----------------------------------------------------------------------------
// two_button_gesture_detector
// Tap / hold gesture detection on two buttons with latched events.
//
// Request channel (req_): func 0 is a timer tick carrying the sampled
// buttons in pressed; func 1 takes the latched events and clears them.
// A tick gives no response; a take gives one response on rsp_.
// Config channel (csr_): writes hold_threshold; always ready.
// A take's response enters the output register, or the skid slot if
// that is full. Throughput: one request per cycle while req_ready is
// high. With the output register and one skid slot, req_ready drops
// only when both hold unaccepted responses, i.e. after two stalled takes.
// Reset: hold_threshold returns to 500, only all_released is latched,
// and gestures are blocked until all buttons are seen released.
// ----------------------------------------------------------------------------
module two_button_gesture_detector
   import tbgd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [1:0] req_pressed,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_left_tap,
   output logic       rsp_right_tap,
   output logic       rsp_both_tap,
   output logic       rsp_both_hold,
   output logic       rsp_all_released,
   output logic       rsp_left_held,
   output logic       rsp_right_held,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [9:0] csr_wdata
);

   count_type threshold_ff;
   logic      req_fire;
   logic      space;
   rsp_type   snapshot;
   rsp_type   rsp_data;

   assign csr_ready = 1'b1;
   assign req_ready = space;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= HOLD_RESET;
      end else if (csr_valid) begin
         threshold_ff <= csr_wdata;
      end
   end

   tbgd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .func      (req_func),
      .pressed   (req_pressed),
      .threshold (threshold_ff),
      .snapshot  (snapshot)
   );

   tbgd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire && req_func == FUNC_TAKE),
      .push_data (snapshot),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_left_tap     = rsp_data.left_tap;
   assign rsp_right_tap    = rsp_data.right_tap;
   assign rsp_both_tap     = rsp_data.both_tap;
   assign rsp_both_hold    = rsp_data.both_hold;
   assign rsp_all_released = rsp_data.all_released;
   assign rsp_left_held    = rsp_data.left_held;
   assign rsp_right_held   = rsp_data.right_held;

endmodule
